### sv/glyph_cache_shelf_packer_top_assert.svh
// Assertion macros shared by the glyph cache shelf packer RTL.
`ifndef GLYPH_CACHE_SHELF_PACKER_TOP_ASSERT_SVH
`define GLYPH_CACHE_SHELF_PACKER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define GCSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define GCSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/gcsp_pkg.sv
// Types, constants and helpers of the glyph cache shelf packer.
package gcsp_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int SIDE_W = 13;
	localparam int POS_W = 12;
	localparam logic [SIDE_W-1:0] SIDE_MAX = 13'd4096;
	localparam logic [SIDE_W-1:0] ROW_SAT = 13'd8191;
	localparam logic [SIDE_W-1:0] INIT_SIDE_RST = 13'd512;
	localparam logic [SIDE_W-1:0] MAX_SIDE_RST = 13'd4096;
	localparam logic [3:0] PAD_RST = 4'd2;

	typedef enum logic [2:0] {
		ST_PLACED     = 3'd0,
		ST_HIT        = 3'd1,
		ST_EMPTY      = 3'd2,
		ST_ATLAS_FULL = 3'd3,
		ST_TABLE_FULL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_INITIAL_SIDE = 2'd0,
		CFG_MAX_SIDE     = 2'd1,
		CFG_PADDING      = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_MISS,
		S_GROW
	} state_t;

	typedef struct packed {
		logic [20:0] codepoint;
		logic [7:0]  glyph_width;
		logic [7:0]  glyph_height;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] place_x;
		logic [POS_W-1:0] place_y;
		logic [7:0]       place_w;
		logic [7:0]       place_h;
		logic [SIDE_W-1:0] atlas_side;
	} res_t;

	// One cache table entry as held in memory.
	typedef struct packed {
		logic [7:0]       h;
		logic [7:0]       w;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] x;
		logic [20:0]      cp;
	} entry_t;

	// Saturate a side register to the legal range 1..4096.
	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		r = v;
		if (v == '0) r = {{(SIDE_W-1){1'b0}}, 1'b1};
		else if (v > SIDE_MAX) r = SIDE_MAX;
		return r;
	endfunction

endpackage

### sv/gcsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gcsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/glyph_cache_shelf_packer_top.sv
// Glyph cache with shelf packing into a growable square atlas: top level.
//
// A request is taken when start is high and busy is low; busy stays high until its
// one result appears on result, marked by done for a single cycle (the receiver cannot
// stall it). The cache table sits in one RAM and is searched one entry per cycle. A
// request ends on a hit, or on a miss after the full search pass over the stored
// entries (up to 256), then the table-full / empty-glyph / row-wrap decision state,
// then any atlas doublings (at most 12) and the placement.
// Configuration writes are taken while busy is low.
module glyph_cache_shelf_packer_top
	import gcsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output res_t        result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [SIDE_W-1:0] cfg_data
);

	`include "glyph_cache_shelf_packer_top_assert.svh"

	state_t state_q, state_d;

	req_t              req_q;
	logic [CNT_W-1:0]  idx_q;
	logic              pend_s1;
	logic [CNT_W-1:0]  cnt_q;
	logic [SIDE_W-1:0] col_q, row_q, side_q;
	logic [7:0]        shelf_q;
	logic [SIDE_W-1:0] max_q;
	logic [3:0]        pad_q;
	logic              done_q;
	res_t              res_q;

	// Control decisions from the next-state block
	logic   issue, hit, we, emit, do_wrap, do_grow, do_place;
	res_t   emit_res;
	entry_t wentry, rentry;
	logic [$bits(entry_t)-1:0] rdata;

	// Placement arithmetic
	logic [SIDE_W:0]   need_col, need_row, wrap_row, grown;
	logic [SIDE_W-1:0] lim;
	logic              col_fits, fits, empty_glyph, table_full;

	assign need_col = {1'b0, col_q} + {{(SIDE_W-7){1'b0}}, req_q.glyph_width}
		+ {{(SIDE_W-3){1'b0}}, pad_q};
	assign need_row = {1'b0, row_q} + {{(SIDE_W-7){1'b0}}, req_q.glyph_height}
		+ {{(SIDE_W-3){1'b0}}, pad_q};
	assign wrap_row = {1'b0, row_q} + {{(SIDE_W-7){1'b0}}, shelf_q}
		+ {{(SIDE_W-3){1'b0}}, pad_q};
	assign grown = {side_q, 1'b0};
	assign lim = clamp_side(max_q);
	assign col_fits = need_col <= {1'b0, side_q};
	assign fits = col_fits && (need_row <= {1'b0, side_q});
	assign empty_glyph = (req_q.glyph_width == '0) || (req_q.glyph_height == '0);
	assign table_full = cnt_q >= CNT_W'(TABLE_ENTRIES);

	assign rentry = entry_t'(rdata);
	assign hit = pend_s1 && (rentry.cp == req_q.codepoint);

	// Cache table
	gcsp_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (wentry),
		.re    (issue),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control
	always_comb begin
		state_d = state_q;
		issue = 1'b0;
		we = 1'b0;
		emit = 1'b0;
		do_wrap = 1'b0;
		do_grow = 1'b0;
		do_place = 1'b0;
		wentry = '{cp: req_q.codepoint, x: '0, y: '0, w: '0, h: '0};
		emit_res = '{status: ST_PLACED, place_x: '0, place_y: '0, place_w: '0,
			place_h: '0, atlas_side: side_q};
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_SEARCH;
			end
			S_SEARCH: begin
				issue = idx_q < cnt_q;
				if (hit) begin
					emit = 1'b1;
					emit_res.status = ST_HIT;
					emit_res.place_x = rentry.x;
					emit_res.place_y = rentry.y;
					emit_res.place_w = rentry.w;
					emit_res.place_h = rentry.h;
					state_d = S_IDLE;
				end else if (!issue && !pend_s1) begin
					state_d = S_MISS;
				end
			end
			S_MISS: begin
				if (table_full) begin
					emit = 1'b1;
					emit_res.status = ST_TABLE_FULL;
					state_d = S_IDLE;
				end else if (empty_glyph) begin
					we = 1'b1;
					emit = 1'b1;
					emit_res.status = ST_EMPTY;
					state_d = S_IDLE;
				end else begin
					do_wrap = !col_fits;
					state_d = S_GROW;
				end
			end
			S_GROW: begin
				if (fits) begin
					we = 1'b1;
					do_place = 1'b1;
					wentry.x = col_q[POS_W-1:0];
					wentry.y = row_q[POS_W-1:0];
					wentry.w = req_q.glyph_width;
					wentry.h = req_q.glyph_height;
					emit = 1'b1;
					emit_res.place_x = col_q[POS_W-1:0];
					emit_res.place_y = row_q[POS_W-1:0];
					emit_res.place_w = req_q.glyph_width;
					emit_res.place_h = req_q.glyph_height;
					state_d = S_IDLE;
				end else if (grown > {1'b0, lim}) begin
					emit = 1'b1;
					emit_res.status = ST_ATLAS_FULL;
					state_d = S_IDLE;
				end else begin
					do_grow = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Packer state, search pointer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			pend_s1 <= 1'b0;
			cnt_q <= '0;
			col_q <= '0;
			row_q <= '0;
			shelf_q <= '0;
			side_q <= INIT_SIDE_RST;
			max_q <= MAX_SIDE_RST;
			pad_q <= PAD_RST;
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
			pend_s1 <= issue && !hit;
			if (state_q == S_IDLE) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (we) cnt_q <= cnt_q + 1'b1;
			if (do_wrap) begin
				col_q <= '0;
				row_q <= (wrap_row > {1'b0, ROW_SAT}) ? ROW_SAT : wrap_row[SIDE_W-1:0];
				shelf_q <= '0;
			end
			if (do_grow) side_q <= grown[SIDE_W-1:0];
			if (do_place) begin
				col_q <= need_col[SIDE_W-1:0];
				if (req_q.glyph_height > shelf_q) shelf_q <= req_q.glyph_height;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_INITIAL_SIDE: side_q <= clamp_side(cfg_data);
					CFG_MAX_SIDE: max_q <= cfg_data;
					CFG_PADDING: pad_q <= cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) req_q <= req;
		if (emit) res_q <= emit_res;
	end

	assign busy = state_q != S_IDLE;
	assign cfg_ready = !busy;
	assign done = done_q;
	assign result = res_q;

	`GCSP_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
	`GCSP_ASSERT_IMP(a_done_after_busy, done, $past(busy), "result without a busy cycle")
	`GCSP_ASSERT_IMP(a_no_stale_read, !busy, !pend_s1, "table read pending while idle")
	`GCSP_ASSERT_NXT(a_count_step, we, cnt_q == $past(cnt_q) + 1'b1, "fill count missed a write")
	`GCSP_ASSERT_IMP(a_placed_inside,
		done && result.status == ST_PLACED,
		{1'b0, result.place_x} + {5'd0, result.place_w} <= result.atlas_side,
		"placed glyph outside atlas")

endmodule
